@@ rtl/s5rp_pkg.sv @@
// Package of shared types and constants for the SOCKS5 request parser.
`timescale 1ns / 1ps

package s5rp_pkg;

  typedef enum logic [3:0] {
    PH_VER     = 4'd0,
    PH_CMD     = 4'd1,
    PH_RSV     = 4'd2,
    PH_ATYP    = 4'd3,
    PH_ADDR    = 4'd4,
    PH_DLEN    = 4'd5,
    PH_PORT    = 4'd6,
    PH_DONE    = 4'd7,
    PH_BADVER  = 4'd8,
    PH_BADCMD  = 4'd9,
    PH_BADTYPE = 4'd10,
    PH_ERROR   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_IPV4   = 2'd1,
    KIND_DOMAIN = 2'd2,
    KIND_IPV6   = 2'd3
  } kind_t;

  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] IPV4_BYTES    = 8'd4;
  localparam logic [7:0] IPV6_BYTES    = 8'd16;
  localparam logic [7:0] PORT_BYTES    = 8'd2;
  localparam logic [7:0] MAX_DLEN_RST  = 8'd255;

  // Payload of one result beat.
  typedef struct packed {
    phase_t      phase;
    kind_t       addr_kind;
    logic        addr_byte_valid;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_byte_index;
    logic [7:0]  domain_len;
    logic [15:0] port;
  } result_t;

endpackage

@@ rtl/s5rp_in_if.sv @@
// Byte channel interface carrying one raw request byte per beat.
`timescale 1ns / 1ps

interface s5rp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

@@ rtl/s5rp_out_if.sv @@
// Result channel interface carrying one parser result per beat.
`timescale 1ns / 1ps

interface s5rp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  phase;
  logic [1:0]  addr_kind;
  logic        addr_byte_valid;
  logic [7:0]  addr_byte;
  logic [7:0]  addr_byte_index;
  logic [7:0]  domain_len;
  logic [15:0] port;

  modport source (output valid, output phase, output addr_kind, output addr_byte_valid,
                  output addr_byte, output addr_byte_index, output domain_len,
                  output port, input ready);
  modport sink   (input valid, input phase, input addr_kind, input addr_byte_valid,
                  input addr_byte, input addr_byte_index, input domain_len,
                  input port, output ready);
endinterface

@@ rtl/socks5_request_parser.sv @@
// Top level of the SOCKS5 request parser: byte-wise request decoding.
`timescale 1ns / 1ps

// The parser walks a SOCKS5 CONNECT request one byte per beat and returns
// exactly one result beat for every input beat. A byte first lands in an
// input register; when the result register is free or being emptied, a
// short block of logic updates the parse state and loads the result
// register. Both stages hand off in the same cycle, so one byte per clock
// is sustained while the output is not stalled. The input register also
// acts as a skid stage: one more byte is taken while a finished result
// waits on a stalled output. Done and error phases hold until a beat with
// start_req set, which restarts the parse with that byte as the version
// byte. The max_dlen_r register (reset 255) bounds the accepted domain
// length; a length of zero or above it ends in the error phase. Write
// cfg_wdata only while no beat is in flight.
module socks5_request_parser
  import s5rp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  s5rp_in_if.sink    in_ch,
  s5rp_out_if.source out_ch
);

  // Configuration register.
  logic [7:0] max_dlen_r;

  // Input stage.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  // Parse state.
  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  rd_cnt_r, rd_cnt_nxt;
  logic [7:0]  exp_cnt_r, exp_cnt_nxt;
  logic [15:0] port_r, port_nxt;
  logic [7:0]  dlen_r, dlen_nxt;

  // Result stage.
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic advance;
  logic in_fire;

  // Working copies after an optional restart.
  phase_t      cur_phase;
  kind_t       cur_kind;
  logic [7:0]  cur_rd;
  logic [7:0]  cur_exp;
  logic [15:0] cur_port;
  logic [7:0]  cur_dlen;
  logic [7:0]  rd_inc;
  logic        cap;
  logic [7:0]  cap_idx;

  // The input register drains whenever the result register is free or
  // being emptied this cycle.
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dlen_r <= MAX_DLEN_RST;
    end else if (cfg_we) begin
      max_dlen_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r  <= in_ch.data_byte;
      in_start_r <= in_ch.start_req;
    end
  end

  // Next parse state for the byte held in the input register.
  always_comb begin
    cur_phase = in_start_r ? PH_VER : phase_r;
    cur_kind  = in_start_r ? KIND_NONE : kind_r;
    cur_rd    = in_start_r ? 8'd0 : rd_cnt_r;
    cur_exp   = in_start_r ? 8'd0 : exp_cnt_r;
    cur_port  = in_start_r ? 16'd0 : port_r;
    cur_dlen  = in_start_r ? 8'd0 : dlen_r;

    rd_inc      = cur_rd + 8'd1;
    phase_nxt   = cur_phase;
    kind_nxt    = cur_kind;
    rd_cnt_nxt  = cur_rd;
    exp_cnt_nxt = cur_exp;
    port_nxt    = cur_port;
    dlen_nxt    = cur_dlen;
    cap         = 1'b0;
    cap_idx     = 8'd0;

    unique case (cur_phase)
      PH_VER: begin
        phase_nxt = (in_byte_r == SOCKS_VERSION) ? PH_CMD : PH_BADVER;
      end
      PH_CMD: begin
        phase_nxt = (in_byte_r == CMD_CONNECT) ? PH_RSV : PH_BADCMD;
      end
      PH_RSV: begin
        // The reserved byte is skipped without a check.
        phase_nxt = PH_ATYP;
      end
      PH_ATYP: begin
        dlen_nxt   = 8'd0;
        rd_cnt_nxt = 8'd0;
        priority if (in_byte_r == ATYP_IPV4) begin
          kind_nxt    = KIND_IPV4;
          exp_cnt_nxt = IPV4_BYTES;
          phase_nxt   = PH_ADDR;
        end else if (in_byte_r == ATYP_IPV6) begin
          kind_nxt    = KIND_IPV6;
          exp_cnt_nxt = IPV6_BYTES;
          phase_nxt   = PH_ADDR;
        end else if (in_byte_r == ATYP_DOMAIN) begin
          kind_nxt  = KIND_DOMAIN;
          phase_nxt = PH_DLEN;
        end else begin
          kind_nxt  = KIND_NONE;
          phase_nxt = PH_BADTYPE;
        end
      end
      PH_DLEN: begin
        if (in_byte_r == 8'd0 || in_byte_r > max_dlen_r) begin
          phase_nxt = PH_ERROR;
        end else begin
          dlen_nxt    = in_byte_r;
          exp_cnt_nxt = in_byte_r;
          rd_cnt_nxt  = 8'd0;
          phase_nxt   = PH_ADDR;
        end
      end
      PH_ADDR: begin
        cap        = 1'b1;
        cap_idx    = cur_rd;
        rd_cnt_nxt = rd_inc;
        // The last address byte hands over to the two port bytes.
        if (rd_inc >= cur_exp) begin
          rd_cnt_nxt  = 8'd0;
          exp_cnt_nxt = PORT_BYTES;
          port_nxt    = 16'd0;
          phase_nxt   = PH_PORT;
        end
      end
      PH_PORT: begin
        port_nxt   = {cur_port[7:0], in_byte_r};
        rd_cnt_nxt = rd_inc;
        if (rd_inc >= cur_exp) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE, PH_BADVER, PH_BADCMD, PH_BADTYPE, PH_ERROR: begin
        // End phases hold until a restart.
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    res_nxt.phase           = phase_nxt;
    res_nxt.addr_kind       = kind_nxt;
    res_nxt.addr_byte_valid = cap;
    res_nxt.addr_byte       = cap ? in_byte_r : 8'd0;
    res_nxt.addr_byte_index = cap_idx;
    res_nxt.domain_len      = (kind_nxt == KIND_DOMAIN) ? dlen_nxt : 8'd0;
    res_nxt.port            = (phase_nxt == PH_DONE) ? port_nxt : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_VER;
      kind_r    <= KIND_NONE;
      rd_cnt_r  <= 8'd0;
      exp_cnt_r <= 8'd0;
      port_r    <= 16'd0;
      dlen_r    <= 8'd0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      exp_cnt_r <= exp_cnt_nxt;
      port_r    <= port_nxt;
      dlen_r    <= dlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.phase           = res_r.phase;
  assign out_ch.addr_kind       = res_r.addr_kind;
  assign out_ch.addr_byte_valid = res_r.addr_byte_valid;
  assign out_ch.addr_byte       = res_r.addr_byte;
  assign out_ch.addr_byte_index = res_r.addr_byte_index;
  assign out_ch.domain_len      = res_r.domain_len;
  assign out_ch.port            = res_r.port;

endmodule
